// File: rtl/gso_pkg.sv
// Package for the Gram-Schmidt orthonormalizer: sizes, state types and
// saturation / load-address helpers. Used by every module under rtl/.
`default_nettype none

package gso_pkg;

   localparam int MAX_ROWS   = 8;
   localparam int MAX_COLS   = 8;
   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 24;
   localparam int ROW_BITS   = 3;
   localparam int DIM_BITS   = 4;
   localparam int ADDR_BITS  = 6;
   localparam int ACC_BITS   = 35;
   localparam int RECIP_BITS = 49;
   localparam int ROOT_BITS  = 28;
   localparam int EPS_BITS   = 31;

   localparam logic [1:0] REG_ROWS = 2'd0;
   localparam logic [1:0] REG_COLS = 2'd1;
   localparam logic [1:0] REG_EPS  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COPY,
      ST_COL,
      ST_RD,
      ST_MUL,
      ST_MWAIT,
      ST_ACC,
      ST_NSTART,
      ST_NORM,
      ST_ZERO,
      ST_ORD,
      ST_OEMIT
   } state_type;

   typedef enum logic [1:0] {
      OP_DOT,
      OP_SUB,
      OP_SQ,
      OP_SCALE
   } op_type;

   typedef enum logic [2:0] {
      N_IDLE,
      N_ROOT,
      N_CHECK,
      N_DIV,
      N_DONE
   } norm_state_type;

   typedef struct packed {
      logic                    done;
      logic                    small_norm;
      logic [RECIP_BITS-1:0]   recip;
   } norm_status_type;

   // Clamp a row or column count to 1..8.
   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
      logic [DIM_BITS-1:0] r;
      r = v;
      if (v == '0) begin
         r = 4'd1;
      end else if (v > 4'(MAX_ROWS)) begin
         r = 4'(MAX_ROWS);
      end
      return r;
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] sat_acc(
      input logic signed [ACC_BITS-1:0] v);
      logic signed [DATA_WIDTH-1:0] r;
      r = v[DATA_WIDTH-1:0];
      if (v > 35'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -35'sh0_8000_0000) begin
         r = -32'sh8000_0000;
      end
      return r;
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] sat_sub(
      input logic signed [DATA_WIDTH-1:0] a, input logic signed [DATA_WIDTH-1:0] b);
      logic signed [DATA_WIDTH:0] d;
      logic signed [DATA_WIDTH-1:0] r;
      d = 33'(a) - 33'(b);
      r = d[DATA_WIDTH-1:0];
      if (d[DATA_WIDTH] != d[DATA_WIDTH-1]) begin
         r = d[DATA_WIDTH] ? -32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

   // Store address {col,row} of load position lc for a given row count.
   // Division by a row count of 3, 5, 6 or 7 is a reciprocal multiply, by a power of two a shift (lc < 64).
   function automatic logic [ADDR_BITS-1:0] load_addr(
      input logic [ADDR_BITS-1:0] lc, input logic [DIM_BITS-1:0] rows);
      logic [15:0] prod;
      logic [5:0]  q;
      logic [9:0]  qr;
      logic [5:0]  rem;
      prod = '0;
      case (rows)
         4'd1: q = lc;
         4'd2: q = {1'b0, lc[5:1]};
         4'd3: begin
            prod = 16'(lc) * 16'd342;
            q = prod[15:10];
         end
         4'd4: q = {2'b00, lc[5:2]};
         4'd5: begin
            prod = 16'(lc) * 16'd205;
            q = prod[15:10];
         end
         4'd6: begin
            prod = 16'(lc) * 16'd171;
            q = prod[15:10];
         end
         4'd7: begin
            prod = 16'(lc) * 16'd147;
            q = prod[15:10];
         end
         default: q = {3'b000, lc[5:3]};
      endcase
      qr  = 10'(q) * 10'(rows);
      rem = lc - qr[5:0];
      return {q[2:0], rem[2:0]};
   endfunction

endpackage

`default_nettype wire

// File: rtl/gram_schmidt_orthonormalizer_unit.sv
// Top level of the modified Gram-Schmidt orthonormalizer (signed Q8.24).
// Depends on gso_pkg, gso_mul and gso_norm.
//
//   channel   handshake            payload
//   request   start / busy         req_in_value, req_in_last
//   response  rsp_valid (strobe)   rsp_out_value, rsp_out_row, rsp_out_col,
//                                  rsp_independent_cols, rsp_out_last
//   config    psel/penable/pwrite  paddr, pwdata, prdata (pready tied high)
//
// While idle, every cycle with start high loads an item. The item marked
// last starts the run: a copy of the store into the work memory, then
// the work on the shared multiplier (one product at a time) and the
// root/divide unit (once a column), then the results, each read and then
// shown. busy stays high for the run.
// Reset is synchronous; it clears control state, the memories keep data.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module gram_schmidt_orthonormalizer_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic signed [gso_pkg::DATA_WIDTH-1:0] req_in_value,
   input  wire logic                                  req_in_last,
   output logic                                       rsp_valid,
   output logic signed [gso_pkg::DATA_WIDTH-1:0]      rsp_out_value,
   output logic [2:0]                                 rsp_out_row,
   output logic [2:0]                                 rsp_out_col,
   output logic [3:0]                                 rsp_independent_cols,
   output logic                                       rsp_out_last,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [3:0]                            paddr,
   input  wire logic [31:0]                           pwdata,
   output logic [31:0]                                prdata,
   output logic                                       pready
);
   import gso_pkg::*;

   // configuration registers
   logic [DIM_BITS-1:0] rows_ff, cols_ff;
   logic [EPS_BITS-1:0] eps_ff;
   logic                csr_write;
   logic [DIM_BITS-1:0] rows_c, cols_c;

   // sequencer state and counters
   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [DIM_BITS-1:0]    i_ff, i_in, j_ff, j_in, kept_ff, kept_in;
   logic [ROW_BITS-1:0]    r_ff, r_in;
   logic [6:0]             lc_ff, lc_in, copy_ff, copy_in;
   logic signed [ACC_BITS-1:0]   acc_ff, acc_in, acc_sum;
   logic signed [DATA_WIDTH-1:0] d_ff, d_in;
   logic [RECIP_BITS-1:0]  recip_ff, recip_in;
   logic                   r_last, j_last;

   // memories
   logic [DATA_WIDTH-1:0]  store_mem [MAX_ROWS*MAX_COLS];
   logic [DATA_WIDTH-1:0]  work_mem [MAX_ROWS*MAX_COLS];
   logic [DATA_WIDTH-1:0]  store_rd_ff, rd_a_ff, rd_b_ff;
   logic                   store_we, work_we;
   logic [ADDR_BITS-1:0]   store_waddr, store_raddr, work_waddr, raddr_a, raddr_b;
   logic [DATA_WIDTH-1:0]  work_wdata;

   // shared units
   logic                         mul_start, mul_done, norm_start;
   logic signed [DATA_WIDTH-1:0] mul_a, mul_res;
   logic signed [RECIP_BITS:0]   mul_b;
   logic [EPS_BITS-1:0]          norm_ss;
   norm_status_type              norm_st;
   logic signed [DATA_WIDTH-1:0] ss_sat;

   // ---- configuration port ----
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= 4'd8;
         cols_ff <= 4'd8;
         eps_ff  <= 31'd1678;
      end else if (csr_write) begin
         case (paddr[3:2])
            REG_ROWS: rows_ff <= pwdata[3:0];
            REG_COLS: cols_ff <= pwdata[3:0];
            REG_EPS:  eps_ff  <= pwdata[30:0];
            default:  eps_ff  <= eps_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_ROWS: prdata = {28'd0, rows_ff};
         REG_COLS: prdata = {28'd0, cols_ff};
         REG_EPS:  prdata = {1'b0, eps_ff};
         default:  prdata = '0;
      endcase
   end

   assign rows_c  = clamp_dim(rows_ff);
   assign cols_c  = clamp_dim(cols_ff);
   assign r_last  = ({1'b0, r_ff} == rows_c - 4'd1);
   assign j_last  = (j_ff == cols_c - 4'd1);
   assign acc_sum = acc_ff + ACC_BITS'(mul_res);
   assign ss_sat  = sat_acc(acc_ff);

   // ---- next state and counters ----
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      r_in     = r_ff;
      kept_in  = kept_ff;
      lc_in    = lc_ff;
      copy_in  = copy_ff;
      acc_in   = acc_ff;
      d_in     = d_ff;
      recip_in = recip_ff;
      case (state_ff)
         ST_IDLE: if (start) begin
            // count the item; saturate the counter
            if (lc_ff != 7'd127) begin
               lc_in = lc_ff + 7'd1;
            end
            if (req_in_last) begin
               lc_in    = '0;
               copy_in  = '0;
               kept_in  = cols_c;
               state_in = ST_COPY;
            end
         end
         ST_COPY: begin
            copy_in = copy_ff + 7'd1;
            if (copy_ff == 7'(MAX_ROWS*MAX_COLS)) begin
               i_in     = '0;
               state_in = ST_COL;
            end
         end
         ST_COL: begin
            j_in   = '0;
            r_in   = '0;
            acc_in = '0;
            if (i_ff == cols_c) begin
               state_in = ST_ORD;
            end else begin
               op_in    = (i_ff == '0) ? OP_SQ : OP_DOT;
               state_in = ST_RD;
            end
         end
         ST_RD:    state_in = ST_MUL;
         ST_MUL:   state_in = ST_MWAIT;
         ST_MWAIT: if (mul_done) begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            state_in = ST_RD;
            r_in     = r_ff + 3'd1;
            case (op_ff)
               OP_DOT: begin
                  acc_in = acc_sum;
                  if (r_last) begin
                     d_in  = sat_acc(acc_sum);
                     op_in = OP_SUB;
                     r_in  = '0;
                  end
               end
               OP_SQ: begin
                  acc_in = acc_sum;
                  if (r_last) begin
                     state_in = ST_NSTART;
                  end
               end
               OP_SUB: if (r_last) begin
                  r_in   = '0;
                  acc_in = '0;
                  j_in   = j_ff + 4'd1;
                  op_in  = (j_ff + 4'd1 < i_ff) ? OP_DOT : OP_SQ;
               end
               default: if (r_last) begin
                  i_in     = i_ff + 4'd1;
                  state_in = ST_COL;
               end
            endcase
         end
         ST_NSTART: state_in = ST_NORM;
         ST_NORM: if (norm_st.done) begin
            r_in = '0;
            if (norm_st.small_norm) begin
               // cut off: drop this column and every later one
               kept_in  = i_ff;
               j_in     = i_ff;
               state_in = ST_ZERO;
            end else begin
               recip_in = norm_st.recip;
               op_in    = OP_SCALE;
               state_in = ST_RD;
            end
         end
         ST_ZERO: begin
            r_in = r_ff + 3'd1;
            if (r_last) begin
               r_in = '0;
               j_in = j_ff + 4'd1;
               if (j_last) begin
                  j_in     = '0;
                  state_in = ST_ORD;
               end
            end
         end
         ST_ORD: state_in = ST_OEMIT;
         ST_OEMIT: begin
            state_in = ST_ORD;
            r_in     = r_ff + 3'd1;
            if (r_last) begin
               r_in = '0;
               j_in = j_ff + 4'd1;
               if (j_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---- datapath controls and outputs ----
   always_comb begin
      store_we    = 1'b0;
      store_waddr = load_addr(lc_ff[5:0], rows_c);
      store_raddr = copy_ff[5:0];
      work_we     = 1'b0;
      work_waddr  = {i_ff[2:0], r_ff};
      work_wdata  = '0;
      raddr_a     = {i_ff[2:0], r_ff};
      raddr_b     = {j_ff[2:0], r_ff};
      mul_start   = 1'b0;
      mul_a       = $signed(rd_a_ff);
      mul_b       = (RECIP_BITS+1)'($signed(rd_b_ff));
      norm_start  = 1'b0;
      norm_ss     = ss_sat[EPS_BITS-1:0];
      rsp_valid   = 1'b0;
      busy        = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            // drop items beyond rows*cols
            store_we = start && ({1'b0, lc_ff} < 8'(rows_c) * 8'(cols_c));
         end
         ST_COPY: begin
            work_we    = (copy_ff != '0);
            work_waddr = 6'(copy_ff - 7'd1);
            work_wdata = store_rd_ff;
         end
         ST_MUL: begin
            mul_start = 1'b1;
            case (op_ff)
               OP_SQ:    mul_b = (RECIP_BITS+1)'($signed(rd_a_ff));
               OP_SUB:   mul_a = d_ff;
               OP_SCALE: mul_b = $signed({1'b0, recip_ff});
               default:  mul_b = (RECIP_BITS+1)'($signed(rd_b_ff));
            endcase
         end
         ST_ACC: begin
            work_we    = (op_ff == OP_SUB) || (op_ff == OP_SCALE);
            work_wdata = (op_ff == OP_SUB) ? sat_sub($signed(rd_a_ff), mul_res) : mul_res;
         end
         ST_NSTART: norm_start = 1'b1;
         ST_ZERO: begin
            work_we    = 1'b1;
            work_waddr = {j_ff[2:0], r_ff};
         end
         ST_ORD:   raddr_a = {j_ff[2:0], r_ff};
         ST_OEMIT: begin
            raddr_a   = {j_ff[2:0], r_ff};
            rsp_valid = 1'b1;
         end
         default: busy = 1'b1;
      endcase
   end

   assign rsp_out_value        = $signed(rd_a_ff);
   assign rsp_out_row          = r_ff;
   assign rsp_out_col          = j_ff[2:0];
   assign rsp_independent_cols = kept_ff;
   assign rsp_out_last         = r_last && j_last;

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         lc_ff    <= lc_in;
      end
      op_ff    <= op_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      r_ff     <= r_in;
      kept_ff  <= kept_in;
      copy_ff  <= copy_in;
      acc_ff   <= acc_in;
      d_ff     <= d_in;
      recip_ff <= recip_in;
   end

   // load store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_waddr] <= req_in_value;
      end
      store_rd_ff <= store_mem[store_raddr];
   end

   // working copy: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (work_we) begin
         work_mem[work_waddr] <= work_wdata;
      end
      rd_a_ff <= work_mem[raddr_a];
      rd_b_ff <= work_mem[raddr_b];
   end

   gso_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .done  (mul_done),
      .res   (mul_res)
   );

   gso_norm u_norm (
      .clock  (clock),
      .reset  (reset),
      .start  (norm_start),
      .ss     (norm_ss),
      .eps    (eps_ff),
      .status (norm_st)
   );

   // ---- checks ----
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   a_mul_wait: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == ST_MWAIT)
      else $error("multiplier finished outside its wait state");

   a_norm_wait: assert property (@(posedge clock) disable iff (reset)
      norm_st.done |-> state_ff == ST_NORM)
      else $error("norm unit finished outside its wait state");

   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_in_last |=> state_ff == ST_COPY)
      else $error("last item did not start the run");

endmodule

`default_nettype wire

// File: rtl/gso_mul.sv
// Shared Q8.24 multiplier: |a|*|b| >> 24, truncated toward zero, saturated.
// Two partial products, 32x25 and 32x24, over successive cycles. Depends on gso_pkg.
`default_nettype none

module gso_mul (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   input  wire logic signed [gso_pkg::DATA_WIDTH-1:0]  op_a,
   input  wire logic signed [gso_pkg::RECIP_BITS:0]    op_b,
   output logic                                        done,
   output logic signed [gso_pkg::DATA_WIDTH-1:0]       res
);
   import gso_pkg::*;

   logic [1:0]            cnt_ff, cnt_in;
   logic [31:0]           ua_ff;
   logic [48:0]           ub_ff;
   logic                  neg_ff;
   logic [56:0]           lo_ff;
   logic [55:0]           hi_ff;
   logic                  done_ff, done_in;
   logic signed [31:0]    res_ff;
   logic [80:0]           full;
   logic [56:0]           mag;
   logic [RECIP_BITS:0]   b_abs;
   logic [DATA_WIDTH-1:0] a_abs;

   always_comb begin
      a_abs = op_a[DATA_WIDTH-1] ? 32'(-op_a) : 32'(op_a);
      b_abs = op_b[RECIP_BITS] ? 50'(-op_b) : 50'(op_b);
      full  = (81'(hi_ff) << 25) + 81'(lo_ff);
      mag   = full[80:24];
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = 2'd1;
      end else if (cnt_ff != 2'd0) begin
         cnt_in = cnt_ff + 2'd1;
         done_in = (cnt_ff == 2'd3);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 2'd0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      if (start) begin
         ua_ff  <= a_abs;
         ub_ff  <= b_abs[48:0];
         neg_ff <= op_a[DATA_WIDTH-1] ^ op_b[RECIP_BITS];
      end
      if (cnt_ff == 2'd1) begin
         lo_ff <= 57'(ua_ff) * 57'(ub_ff[24:0]);
      end
      if (cnt_ff == 2'd2) begin
         hi_ff <= 56'(ua_ff) * 56'(ub_ff[48:25]);
      end
      if (cnt_ff == 2'd3) begin
         if (neg_ff) begin
            res_ff <= (mag >= 57'h0_8000_0000) ? -32'sh8000_0000 : -$signed(mag[31:0]);
         end else begin
            res_ff <= (mag > 57'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(mag[31:0]);
         end
      end
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

`default_nettype wire

// File: rtl/gso_norm.sv
// Column norm and reciprocal: bit-serial square root of ss*2^24, threshold
// check, then (if the norm passes) restoring division 2^48/norm one bit a cycle. Uses gso_pkg.
`default_nettype none

module gso_norm (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [gso_pkg::EPS_BITS-1:0]     ss,
   input  wire logic [gso_pkg::EPS_BITS-1:0]     eps,
   output gso_pkg::norm_status_type              status
);
   import gso_pkg::*;

   norm_state_type         nstate_ff, nstate_in;
   logic [5:0]             cnt_ff;
   logic [55:0]            rad_ff;
   logic [31:0]            rem_ff;
   logic [ROOT_BITS-1:0]   root_ff;
   logic [RECIP_BITS-1:0]  quo_ff;
   logic                   small_ff;
   logic [31:0]            rsh, trial, dsh;
   logic                   small_now;

   always_comb begin
      rsh       = {rem_ff[29:0], rad_ff[55:54]};
      trial     = {2'b00, root_ff, 2'b01};
      dsh       = {rem_ff[30:0], (cnt_ff == 6'd0)};
      small_now = (root_ff == '0) || ({3'b000, root_ff} < eps);
   end

   always_comb begin
      nstate_in = nstate_ff;
      case (nstate_ff)
         N_IDLE:  if (start) begin
            nstate_in = N_ROOT;
         end
         N_ROOT:  if (cnt_ff == 6'(ROOT_BITS - 1)) begin
            nstate_in = N_CHECK;
         end
         N_CHECK: nstate_in = small_now ? N_DONE : N_DIV;
         N_DIV:   if (cnt_ff == 6'(RECIP_BITS - 1)) begin
            nstate_in = N_DONE;
         end
         N_DONE:  nstate_in = N_IDLE;
         default: nstate_in = N_IDLE;
      endcase
   end

   always_comb begin
      status.done       = (nstate_ff == N_DONE);
      status.small_norm = small_ff;
      status.recip      = quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nstate_ff <= N_IDLE;
      end else begin
         nstate_ff <= nstate_in;
      end
      case (nstate_ff)
         N_IDLE: begin
            rad_ff  <= {1'b0, ss, 24'd0};
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= '0;
         end
         N_ROOT: begin
            if (rsh >= trial) begin
               rem_ff  <= rsh - trial;
               root_ff <= {root_ff[ROOT_BITS-2:0], 1'b1};
            end else begin
               rem_ff  <= rsh;
               root_ff <= {root_ff[ROOT_BITS-2:0], 1'b0};
            end
            rad_ff <= {rad_ff[53:0], 2'b00};
            cnt_ff <= cnt_ff + 6'd1;
         end
         N_CHECK: begin
            small_ff <= small_now;
            rem_ff   <= '0;
            quo_ff   <= '0;
            cnt_ff   <= '0;
         end
         N_DIV: begin
            if (dsh >= {4'd0, root_ff}) begin
               rem_ff <= dsh - {4'd0, root_ff};
               quo_ff <= {quo_ff[RECIP_BITS-2:0], 1'b1};
            end else begin
               rem_ff <= dsh;
               quo_ff <= {quo_ff[RECIP_BITS-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 6'd1;
         end
         default: begin
            cnt_ff <= cnt_ff;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: tb/tb_gram_schmidt_orthonormalizer_unit.sv
// Self-checking bench for gram_schmidt_orthonormalizer_unit: loads random
// and directed matrices, predicts each orthonormalized element in Q8.24.
// Depends on gso_pkg and the RTL under rtl/.
`default_nettype none

module tb_gram_schmidt_orthonormalizer_unit;
   import gso_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;

   typedef struct {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         last;
   } load_item_t;

   typedef struct {
      logic signed [DATA_WIDTH-1:0] value;
      logic [2:0]                   row;
      logic [2:0]                   col;
      logic [3:0]                   kept;
      logic                         last;
   } ortho_elem_t;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic signed [DATA_WIDTH-1:0] req_in_value;
   logic                         req_in_last;
   logic                         rsp_valid;
   logic signed [DATA_WIDTH-1:0] rsp_out_value;
   logic [2:0]                   rsp_out_row;
   logic [2:0]                   rsp_out_col;
   logic [3:0]                   rsp_independent_cols;
   logic                         rsp_out_last;
   logic                         psel;
   logic                         penable;
   logic                         pwrite;
   logic [3:0]                   paddr;
   logic [31:0]                  pwdata;
   logic [31:0]                  prdata;
   logic                         pready;

   gram_schmidt_orthonormalizer_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_in_value(req_in_value), .req_in_last(req_in_last),
      .rsp_valid(rsp_valid), .rsp_out_value(rsp_out_value),
      .rsp_out_row(rsp_out_row), .rsp_out_col(rsp_out_col),
      .rsp_independent_cols(rsp_independent_cols), .rsp_out_last(rsp_out_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   load_item_t   load_queue[$];
   ortho_elem_t  ortho_expected[$];
   int           error_count = 0;
   int           quiet_cycles = 0;
   int           items_queued = 0;
   bit           idle_enable = 1'b1;

   // Shadow of the block: configuration and loaded store.
   logic [3:0]   cfg_rows = 4'd8;
   logic [3:0]   cfg_cols = 4'd8;
   logic [30:0]  cfg_eps  = 31'd1678;
   longint       matrix_mem[64];
   int           load_pos = 0;
   bit           written[64];

   function automatic int eff_dim(logic [3:0] v);
      if (v == 0) return 1;
      return (v > 8) ? 8 : int'(v);
   endfunction

   function automatic longint sat32(longint v);
      if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return -64'sh8000_0000;
      return v;
   endfunction

   // (a*b)>>24 with magnitude truncated, then saturated to 32 bits.
   function automatic longint q_mul(longint a, longint b);
      bit neg;
      longint unsigned ua, ub, ah, al, bh, bl, hh, mag, mx;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      mx = 64'h7FFF_FFFF;
      ah = ua >> 24; al = ua & 64'hFF_FFFF;
      bh = ub >> 24; bl = ub & 64'hFF_FFFF;
      hh = ah * bh;
      if (hh > (mx >> 24)) mag = mx + 2;
      else mag = (hh << 24) + ah * bl + al * bh + ((al * bl) >> 24);
      if (neg) return (mag > mx + 1) ? -64'sh8000_0000 : -longint'(mag);
      return (mag > mx) ? longint'(mx) : longint'(mag);
   endfunction

   function automatic longint col_dot(ref longint w[64], input int ca, int cb, int rows);
      longint acc;
      acc = 0;
      for (int r = 0; r < rows; r++) acc += q_mul(w[ca*8+r], w[cb*8+r]);
      return sat32(acc);
   endfunction

   // floor(sqrt(ss * 2^24)), bit by bit.
   function automatic longint unsigned q_root(longint ss);
      logic [71:0] x;
      longint unsigned rem, root, trial;
      x = (ss < 0) ? 72'd0 : (72'(ss) << 24);
      rem = 0;
      root = 0;
      for (int p = 35; p >= 0; p--) begin
         rem = (rem << 2) | longint'(x[2*p+1 -: 2]);
         trial = (root << 2) | 1;
         if (rem >= trial) begin
            rem -= trial;
            root = (root << 1) | 1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   // Take one accepted item; on the last one push the whole result run.
   task automatic orthonormalize_item(logic signed [31:0] v, logic last);
      int rows, cols, kept;
      longint w[64];
      longint d, ss;
      longint unsigned nrm, recip;
      ortho_elem_t e;
      rows = eff_dim(cfg_rows);
      cols = eff_dim(cfg_cols);
      if (load_pos < rows*cols)
         matrix_mem[(load_pos / rows)*8 + load_pos % rows] = longint'(v);
      if (load_pos < 127) load_pos++;
      if (!last) return;
      load_pos = 0;
      w = matrix_mem;
      kept = cols;
      for (int i = 0; i < cols; i++) begin
         for (int j = 0; j < i; j++) begin
            d = col_dot(w, i, j, rows);
            for (int r = 0; r < rows; r++)
               w[i*8+r] = sat32(w[i*8+r] - q_mul(d, w[j*8+r]));
         end
         ss = col_dot(w, i, i, rows);
         nrm = q_root(ss);
         if (nrm > 64'h7FFF_FFFF) nrm = 64'h7FFF_FFFF;
         if (nrm == 0 || nrm < cfg_eps) begin
            // Drop this column and every later one.
            kept = i;
            for (int j = i; j < cols; j++)
               for (int r = 0; r < rows; r++) w[j*8+r] = 0;
            break;
         end
         recip = (64'd1 << 48) / nrm;
         for (int r = 0; r < rows; r++) w[i*8+r] = q_mul(w[i*8+r], longint'(recip));
      end
      for (int j = 0; j < cols; j++) begin
         for (int r = 0; r < rows; r++) begin
            e.value = w[j*8+r][31:0];
            e.row   = r[2:0];
            e.col   = j[2:0];
            e.kept  = kept[3:0];
            e.last  = (j == cols-1 && r == rows-1);
            ortho_expected.push_back(e);
         end
      end
   endtask

   task automatic report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      error_count++;
   endtask

   // Driver: advance on accept; while idling is enabled, skip a chance to send with probability 23/100.
   always @(posedge clock) begin
      load_item_t it;
      bit accepted;
      accepted = 1'b0;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            accepted = 1'b1;
            orthonormalize_item(req_in_value, req_in_last);
         end
         if (!start || accepted) begin
            if (load_queue.size() > 0 && !(idle_enable && $urandom_range(99) < 23)) begin
               it = load_queue.pop_front();
               start        <= 1'b1;
               req_in_value <= it.value;
               req_in_last  <= it.last;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each strobed element with the oldest prediction.
   always @(posedge clock) begin
      ortho_elem_t e;
      if (!reset && rsp_valid) begin
         if (ortho_expected.size() == 0) begin
            report_mismatch("element with no prediction waiting");
         end else begin
            e = ortho_expected.pop_front();
            if (rsp_out_value !== e.value)
               report_mismatch($sformatf("value %h, predicted %h (r%0d c%0d)",
                                         rsp_out_value, e.value, e.row, e.col));
            if (rsp_out_row !== e.row)
               report_mismatch($sformatf("row %0d, predicted %0d", rsp_out_row, e.row));
            if (rsp_out_col !== e.col)
               report_mismatch($sformatf("col %0d, predicted %0d", rsp_out_col, e.col));
            if (rsp_independent_cols !== e.kept)
               report_mismatch($sformatf("kept %0d, predicted %0d",
                                         rsp_independent_cols, e.kept));
            if (rsp_out_last !== e.last)
               report_mismatch($sformatf("last %0b, predicted %0b", rsp_out_last, e.last));
         end
      end
   end

   // Watchdog: count cycles in which neither side moves an item.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d quiet cycles", quiet_cycles);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_ROWS: cfg_rows = data[3:0];
         REG_COLS: cfg_cols = data[3:0];
         REG_EPS:  cfg_eps  = data[30:0];
         default: ;
      endcase
   endtask

   task automatic set_shape(logic [3:0] rows, logic [3:0] cols, logic [30:0] eps);
      csr_write(REG_ROWS, {28'd0, rows});
      csr_write(REG_COLS, {28'd0, cols});
      csr_write(REG_EPS, {1'b0, eps});
   endtask

   // Hold until every item is in and every element is out, then let the
   // block settle.
   task automatic drain();
      do @(posedge clock);
      while (load_queue.size() > 0 || start || ortho_expected.size() > 0);
      repeat (30) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_elem();
      case ($urandom_range(9))
         0:       return $urandom;
         1:       return 32'sh7FFF_FFFF;
         2:       return -32'sh8000_0000;
         3:       return 32'sh0;
         default: return $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
      endcase
   endfunction

   // Queue one matrix of count elements; count may be short of or exceed
   // the shape. A column may repeat column 0 to force a cutoff.
   task automatic queue_matrix(int count, bit dup_cols);
      int rows, n;
      logic signed [31:0] col0[8];
      load_item_t it;
      rows = eff_dim(cfg_rows);
      n = rows * eff_dim(cfg_cols);
      for (int k = 0; k < count; k++) begin
         it.value = rand_elem();
         if (k < rows) col0[k] = it.value;
         else if (dup_cols && k < n && (k / rows) % 2 == 1) it.value = col0[k % rows];
         it.last = (k == count - 1);
         if (k < n) written[(k / rows)*8 + k % rows] = 1'b1;
         load_queue.push_back(it);
         items_queued++;
      end
   endtask

   // Pick a load length: full, short when the missing entries are known,
   // or with extra elements.
   function automatic int pick_count();
      int n, m, rows;
      bit ok;
      rows = eff_dim(cfg_rows);
      n = rows * eff_dim(cfg_cols);
      case ($urandom_range(9))
         0: begin
            m = $urandom_range(n, 1);
            ok = 1'b1;
            for (int k = m; k < n; k++) if (!written[(k / rows)*8 + k % rows]) ok = 1'b0;
            return ok ? m : n;
         end
         1: return n + $urandom_range(6, 1);
         default: return n;
      endcase
   endfunction

   initial begin
      load_item_t it;
      reset        = 1'b1;
      start        = 1'b0;
      req_in_value = '0;
      req_in_last  = 1'b0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      for (int k = 0; k < 64; k++) begin
         matrix_mem[k] = 0;
         written[k]    = 1'b0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero row count and oversized column count clamp, zero
      // threshold with a zero column (zero norm still cuts off).
      set_shape(4'd0, 4'd15, 31'd0);
      for (int k = 0; k < 8; k++) begin
         it.value = (k == 3) ? 32'sh0 : (k == 0 ? 32'sh7FFF_FFFF : -32'sh8000_0000);
         it.last  = (k == 7);
         load_queue.push_back(it);
         items_queued++;
      end
      written[0] = 1'b1;
      drain();
      // Largest threshold: every column is dropped.
      set_shape(4'd2, 4'd2, 31'h7FFF_FFFF);
      queue_matrix(4, 1'b0);
      drain();
      // Short load reusing stored entries, then a load with extra elements.
      set_shape(4'd1, 4'd1, 31'd1678);
      queue_matrix(1, 1'b0);
      drain();
      set_shape(4'd2, 4'd2, 31'd1678);
      queue_matrix(4, 1'b1);
      drain();
      queue_matrix(2, 1'b0);
      drain();
      set_shape(4'd1, 4'd2, 31'd1678);
      queue_matrix(9, 1'b0);
      drain();

      // Random: mostly small shapes, now and then any shape up to the full one.
      for (int m = 0; items_queued < 110 - 64; m++) begin
         int cnt;
         if (m == 0 || $urandom_range(1)) begin
            if ($urandom_range(9) == 0)
               set_shape(4'($urandom_range(15)), 4'($urandom_range(15)),
                         $urandom_range(2) == 0 ? 31'd0 : 31'd1678);
            else
               set_shape(4'($urandom_range(4, 1)), 4'($urandom_range(4, 1)),
                         $urandom_range(3) == 0 ? 31'($urandom_range(32'h0100_0000))
                                                : 31'd1678);
         end
         cnt = pick_count();
         queue_matrix(cnt, $urandom_range(3) == 0);
         drain();
      end
      // Full shape back to back: the stretch without idling.
      idle_enable = 1'b0;
      set_shape(4'd8, 4'd8, 31'd1678);
      queue_matrix(64, 1'b0);
      drain();

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
rtl/gso_pkg.sv
rtl/gso_mul.sv
rtl/gso_norm.sv
rtl/gram_schmidt_orthonormalizer_unit.sv
tb/tb_gram_schmidt_orthonormalizer_unit.sv
